// ----- src/pointer_transition_fifo_top_defines.svh -----
// ---------------------------------------------------------------------------
// Pointer transition FIFO assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef POINTER_TRANSITION_FIFO_TOP_DEFINES_SVH
`define POINTER_TRANSITION_FIFO_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PTF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ptf_pkg.sv -----
// ---------------------------------------------------------------------------
// Pointer transition FIFO package
// Shared types, codes and reset constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptf_pkg;

  localparam int FIFO_DEPTH_DEF = 64;
  localparam int LIMIT_W        = 7;
  localparam logic [LIMIT_W-1:0] BURST_LIMIT_RST = 7'd16;

  // register index taken from the configuration address
  localparam logic REG_BURST_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    FUNC_DOWN = 2'd0,
    FUNC_MOVE = 2'd1,
    FUNC_UP   = 2'd2,
    FUNC_READ = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic        pressed;
    logic [15:0] y;
    logic [15:0] x;
  } entry_t;

  typedef struct packed {
    logic capture;  // latch the incoming word
    logic exec;     // apply the latched item and load the result
  } cmd_t;

  typedef struct packed {
    logic out_free;  // result register empty or being drained this cycle
  } status_t;

endpackage

// ----- src/ptf_ctrl.sv -----
// ---------------------------------------------------------------------------
// Pointer transition FIFO controller
// Two-state sequencer: capture an item, then execute it once the result
// register can take the answer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  ptf_pkg::status_t status,
  output ptf_pkg::cmd_t    cmd
);

  ptf_pkg::state_t state_r;
  ptf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptf_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = ptf_pkg::ST_EXEC;
      end
      ptf_pkg::ST_EXEC: begin
        if (status.out_free) state_nxt = ptf_pkg::ST_IDLE;
      end
      default: state_nxt = ptf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      ptf_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ptf_pkg::ST_EXEC: begin
        cmd.exec = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/ptf_datapath.sv -----
// ---------------------------------------------------------------------------
// Pointer transition FIFO datapath
// Entry memory, ring pointers, held point, burst counter and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptf_datapath #(
  parameter int FIFO_DEPTH = ptf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptf_pkg::cmd_t               cmd,
  output ptf_pkg::status_t            status,
  input  logic [1:0]                  in_func,
  input  logic [15:0]                 in_x,
  input  logic [15:0]                 in_y,
  input  logic [ptf_pkg::LIMIT_W-1:0] burst_limit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_accepted,
  output logic [15:0]                 out_point_x,
  output logic [15:0]                 out_point_y,
  output logic                        out_is_pressed,
  output logic                        out_continue
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int LW = ptf_pkg::LIMIT_W;

  ptf_pkg::entry_t mem [FIFO_DEPTH];
  ptf_pkg::entry_t rd_entry_r;
  ptf_pkg::entry_t wr_entry;

  ptf_pkg::func_t  func_r;
  logic [15:0]     x_r, y_r;

  logic [AW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [15:0]     cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic            cur_p_r, cur_p_nxt;
  logic            newest_p_r, newest_p_nxt;
  logic [LW-1:0]   burst_r, burst_nxt, burst_inc;

  logic            out_valid_r;
  logic            acc_r, acc_nxt, cont_r, cont_nxt;
  logic [15:0]     ox_r, oy_r;
  logic            op_r;

  logic            full, empty, is_read, wr_en, pop, burst_end, push_p;

  // capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= ptf_pkg::func_t'(in_func);
      x_r    <= in_x;
      y_r    <= in_y;
    end
  end

  // entry memory: one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (wr_en) mem[tail_r] <= wr_entry;
    rd_entry_r <= mem[head_r];
  end

  assign full    = (count_r == CW'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign is_read = (func_r == ptf_pkg::FUNC_READ);

  always_comb begin
    unique case (func_r)
      ptf_pkg::FUNC_DOWN: push_p = 1'b1;
      ptf_pkg::FUNC_UP:   push_p = 1'b0;
      ptf_pkg::FUNC_MOVE: push_p = empty ? cur_p_r : newest_p_r;
      default:            push_p = 1'b0;
    endcase
  end

  assign wr_entry  = '{pressed: push_p, y: y_r, x: x_r};
  assign wr_en     = cmd.exec && !is_read && !full;
  assign pop       = cmd.exec && is_read && !empty;
  assign burst_inc = burst_r + LW'(1);
  assign burst_end = (count_r == CW'(1)) || (burst_inc >= burst_limit);

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    cur_p_nxt    = cur_p_r;
    newest_p_nxt = newest_p_r;
    burst_nxt    = burst_r;
    if (wr_en) begin
      tail_nxt     = (tail_r == AW'(FIFO_DEPTH - 1)) ? '0 : tail_r + AW'(1);
      count_nxt    = count_r + CW'(1);
      newest_p_nxt = push_p;
    end
    if (pop) begin
      head_nxt  = (head_r == AW'(FIFO_DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
      cur_x_nxt = rd_entry_r.x;
      cur_y_nxt = rd_entry_r.y;
      cur_p_nxt = rd_entry_r.pressed;
      burst_nxt = burst_end ? '0 : burst_inc;
    end
    acc_nxt  = is_read || !full;
    cont_nxt = pop && !burst_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cur_p_r     <= 1'b0;
      newest_p_r  <= 1'b0;
      burst_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      cur_p_r    <= cur_p_nxt;
      newest_p_r <= newest_p_nxt;
      burst_r    <= burst_nxt;
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, loaded with the state after the item
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_r  <= acc_nxt;
      cont_r <= cont_nxt;
      ox_r   <= cur_x_nxt;
      oy_r   <= cur_y_nxt;
      op_r   <= cur_p_nxt;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_accepted    = acc_r;
  assign out_point_x     = ox_r;
  assign out_point_y     = oy_r;
  assign out_is_pressed  = op_r;
  assign out_continue    = cont_r;

endmodule

// ----- src/pointer_transition_fifo_top.sv -----
// ---------------------------------------------------------------------------
// Pointer transition FIFO
// Ring buffer of touch-pointer transitions with burst-limited read-out.
//
//  port group | dir | contents
//  in_*       | in  | tuser: func; tdata: x_coord, y_coord
//  out_*      | out | tdata: accepted, point_x, point_y, is_pressed,
//             |     |        read_more
//  cfg_*      | in  | APB register burst_limit at byte address 0
//
// One item at a time: capture then execute, the execute cycle waiting on the
// entry memory's registered read at the head pointer.
// The execute cycle stalls while the result register holds a word not taken.
// Reset is synchronous; the entry memory is not cleared and is ready at once.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pointer_transition_fifo_top_defines.svh"

module pointer_transition_fifo_top #(
  parameter int FIFO_DEPTH = ptf_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] x_coord, [31:16] y_coord
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] accepted, [16:1] point_x, [32:17] point_y,
                                  // [33] is_pressed, [34] read_more, zeros
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int LW = ptf_pkg::LIMIT_W;

  ptf_pkg::cmd_t    cmd;
  ptf_pkg::status_t status;

  logic [LW-1:0] limit_r;
  logic          cfg_wr;
  logic          acc, prs, cont;
  logic [15:0]   px, py;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ptf_pkg::BURST_LIMIT_RST;
    end else if (cfg_wr && (cfg_paddr[2] == ptf_pkg::REG_BURST_LIMIT)) begin
      limit_r <= cfg_pwdata[LW-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == ptf_pkg::REG_BURST_LIMIT) ?
                      {{(32-LW){1'b0}}, limit_r} : 32'd0;

  ptf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ptf_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_func        (in_tuser),
    .in_x           (in_tdata[15:0]),
    .in_y           (in_tdata[31:16]),
    .burst_limit    (limit_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_accepted   (acc),
    .out_point_x    (px),
    .out_point_y    (py),
    .out_is_pressed (prs),
    .out_continue   (cont)
  );

  assign out_tdata = {5'd0, cont, prs, py, px, acc};

  // one item in flight: the cycle after a capture never takes another word
  `PTF_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "second capture")
  // never overwrite a result that is still waiting
  `PTF_ASSERT_IMPLY(a_no_overwrite, cmd.exec, !out_tvalid || out_tready, "result overwrite")
  // a new result appears only after an execute cycle
  `PTF_ASSERT_IMPLY(a_valid_source, $rose(out_tvalid), $past(cmd.exec), "result without item")

endmodule
